/* design/spq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg - shared types and constants of the sorted priority queue
// entry layout, opcodes, status codes and sizing of the cell row
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int VALUE_W     = 32;
  localparam int PRIO_W      = 16;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 5;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic signed [PRIO_W-1:0]  prio;
  } entry_t;

  // broadcast to every cell of the row
  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t new_entry;
  } cell_ctrl_t;

endpackage
`default_nettype wire

/* design/spq_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_cell - one slot of the sorted queue
// holds an entry, keeps it, takes the new entry or takes a neighbor's entry
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  wire logic       clk,
  input  wire cell_ctrl_t ctrl,
  input  wire logic       occupied,
  input  wire logic       left_keep,
  input  wire entry_t     left_data,
  input  wire entry_t     right_data,
  output logic            keep,
  output entry_t          data
);

  entry_t data_r;
  entry_t data_nxt;

  // an occupied slot at or above the new priority stays in place
  assign keep = occupied &&
                ($signed(data_r.prio) >= $signed(ctrl.new_entry.prio));
  assign data = data_r;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.enq && !keep) begin
      data_nxt = left_keep ? ctrl.new_entry : left_data;
    end else if (ctrl.deq) begin
      data_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule
`default_nettype wire

/* design/sorted_priority_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue - priority queue kept sorted in a row of cells
// enqueue inserts behind all entries of greater or equal priority,
// dequeue pops the head; each request reports status, head and count
// ----------------------------------------------------------------------------
// result: the strobe comes in the cycle after the request is taken
// throughput: 1 request per cycle, busy is never raised; every cell compares
//   and shifts in parallel in the same cycle the request is taken
// reset: rst_n (synchronous) empties the queue and clears the strobe
// the receiver cannot stall, so each result is shown for exactly one cycle
// ----------------------------------------------------------------------------
module sorted_priority_queue
  import spq_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic                    in_opcode,
  input  wire logic signed [31:0]      in_entry_value,
  input  wire logic signed [15:0]      in_entry_priority,
  output logic                         out_valid,
  output logic [STATUS_W-1:0]          out_status,
  output logic signed [31:0]           out_removed_value,
  output logic signed [15:0]           out_removed_priority,
  output logic signed [31:0]           out_head_value,
  output logic signed [15:0]           out_head_priority,
  output logic [COUNT_OUT_W-1:0]       out_entry_count,
  output logic                         out_queue_empty
);

  // request handshake: every cycle can take a request
  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // fill count, the cells themselves carry no valid bits
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  logic is_full;
  logic is_empty;
  assign is_full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign is_empty = (count_r == '0);

  entry_t new_entry;
  assign new_entry.value = in_entry_value;
  assign new_entry.prio  = in_entry_priority;

  // broadcast control, only legal operations move the row
  cell_ctrl_t ctrl;
  assign ctrl.enq       = accept && (in_opcode == OP_ENQ) && !is_full;
  assign ctrl.deq       = accept && (in_opcode == OP_DEQ) && !is_empty;
  assign ctrl.new_entry = new_entry;

  // the cell row
  entry_t                 cell_data [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_keep;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic   occ;
    logic   lkeep;
    entry_t ldata;
    entry_t rdata;

    assign occ = (count_r > CNT_W'(i));

    // the head has no left neighbor: it always loads the new entry when it moves on an enqueue
    if (i == 0) begin : g_first
      assign lkeep = 1'b1;
      assign ldata = new_entry;
    end else begin : g_inner
      assign lkeep = cell_keep[i-1];
      assign ldata = cell_data[i-1];
    end

    // the tail shifts in an empty entry on a dequeue
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign rdata = '0;
    end else begin : g_body
      assign rdata = cell_data[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (occ),
      .left_keep  (lkeep),
      .left_data  (ldata),
      .right_data (rdata),
      .keep       (cell_keep[i]),
      .data       (cell_data[i])
    );
  end

  // result of the request, formed from the row before it moves
  logic [STATUS_W-1:0] status_nxt;
  entry_t              removed_nxt;
  entry_t              head_nxt;

  always_comb begin
    count_nxt   = count_r;
    status_nxt  = STAT_DONE;
    removed_nxt = '0;
    head_nxt    = is_empty ? '0 : cell_data[0];
    if (in_opcode == OP_ENQ) begin
      if (is_full) begin
        status_nxt = STAT_FULL;
      end else begin
        count_nxt = count_r + CNT_W'(1);
        // new head unless the old head outranks or ties it
        head_nxt  = cell_keep[0] ? cell_data[0] : new_entry;
      end
    end else begin
      if (is_empty) begin
        status_nxt = STAT_EMPTY;
      end else begin
        count_nxt   = count_r - CNT_W'(1);
        removed_nxt = cell_data[0];
        head_nxt    = (count_r > CNT_W'(1)) ? cell_data[1] : '0;
      end
    end
  end

  logic [31:0] count_wide;
  assign count_wide = 32'(count_nxt);

  // control state
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  // result register
  logic [STATUS_W-1:0]    status_r;
  entry_t                 removed_r;
  entry_t                 head_r;
  logic [COUNT_OUT_W-1:0] entry_count_r;
  logic                   queue_empty_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r      <= status_nxt;
      removed_r     <= removed_nxt;
      head_r        <= head_nxt;
      entry_count_r <= count_wide[COUNT_OUT_W-1:0];
      queue_empty_r <= (count_nxt == '0);
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = status_r;
  assign out_removed_value    = removed_r.value;
  assign out_removed_priority = removed_r.prio;
  assign out_head_value       = head_r.value;
  assign out_head_priority    = head_r.prio;
  assign out_entry_count      = entry_count_r;
  assign out_queue_empty      = queue_empty_r;

  // checks

  // the fill count never passes the depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("fill count beyond queue depth");

  // one strobe per request, in the next cycle
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("request without result strobe");

  // a full rejection leaves the queue full
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STAT_FULL)) |-> (count_r == CNT_W'(QUEUE_DEPTH)))
    else $error("full rejection but queue not full");

  // the two front slots stay in descending priority order
  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CNT_W'(2)) |-> ($signed(cell_data[0].prio) >= $signed(cell_data[1].prio)))
    else $error("front slots out of priority order");

endmodule
`default_nettype wire
